// File: src/gre_pkg.sv
// Package for the graph reachability engine: shared constants, codes and types.
package gre_pkg;

  // Field widths.
  localparam int NODE_W = 6;
  localparam int COUNT_W = 7;

  // Defaults.
  localparam int DEFAULT_MAX_NODES = 64;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  // Request operation codes.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR_A,
    S_ADD_WR_B,
    S_PICK,
    S_EXPAND
  } state_t;

  // Control strobes from the sequencer to the adjacency memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: src/gre_adj_mem.sv
// Adjacency row memory with per-row valid bits so that reset clears it at once.
module gre_adj_mem #(
  parameter int MAX_NODES = gre_pkg::DEFAULT_MAX_NODES,
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gre_pkg::mem_ctl_t    ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [MAX_NODES-1:0] wr_data,
  output logic [MAX_NODES-1:0] rd_data
);

  logic [MAX_NODES-1:0] rows [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rows[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= rows[rd_addr];
    end
  end

  // A row that was never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// File: src/graph_reachability_engine.sv
// Top level of the graph reachability engine: sequencer, walk state and result register.
//
// The block holds an undirected graph as one adjacency row per node in a memory with a
// single read and a single write port and registered read data. A request is taken
// when start is high and busy is low. An add request (op low) sets the two symmetric
// edge bits through a read, a write-A and a write-B state, one read and write per
// endpoint, and gives no result; an add with an endpoint at or above the node count is
// dropped. A query request (op high) answers whether node_b can be reached from node_a.
// A query with an endpoint at or above the node count, or with equal endpoints, is
// answered in the cycle after acceptance without raising busy. Otherwise the walk keeps
// a reached vector and an expanded vector in flip-flops and expands one reached node at
// a time: S_PICK issues the row read and S_EXPAND merges the row. The answer appears on
// reachable, marked by done for exactly one cycle; the receiver cannot stall it, so it
// must take the result in that cycle. The node_count register is written through the
// cfg channel only while the block is idle, a rule for the user that the block does not
// enforce; cfg is always ready. Reset clears the adjacency store at once through per-row
// valid bits, with no clearing pass, and sets node_count to 64.
module graph_reachability_engine #(
  parameter int MAX_NODES = gre_pkg::DEFAULT_MAX_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [gre_pkg::NODE_W-1:0]  node_a,
  input  logic [gre_pkg::NODE_W-1:0]  node_b,
  output logic                        done,
  output logic                        reachable,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gre_pkg::COUNT_W-1:0] cfg_data
);

  // Node index width, padded power-of-two width for the search, and count width.
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PW = 1 << AW;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int KW = (CW > gre_pkg::COUNT_W) ? CW : gre_pkg::COUNT_W;

  gre_pkg::state_t      state;
  gre_pkg::state_t      state_next;
  gre_pkg::mem_ctl_t    mem_ctl;

  logic [gre_pkg::COUNT_W-1:0] node_count;
  logic [KW-1:0]               count_act;
  logic [MAX_NODES-1:0]        count_mask;
  logic                        req_valid;
  logic                        accept;
  logic                        direct_answer;

  logic [AW-1:0]        a_q;
  logic [AW-1:0]        b_q;
  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] expanded;
  logic [MAX_NODES-1:0] pending;
  logic [AW-1:0]        pick;

  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [MAX_NODES-1:0] wr_data;
  logic [MAX_NODES-1:0] rd_data;

  logic done_q;
  logic reach_q;

  // Lowest set bit by halving: one narrow test per index bit.
  function automatic logic [AW-1:0] first_set(input logic [MAX_NODES-1:0] v);
    logic [PW-1:0] w;
    logic [PW-1:0] low_mask;
    logic [AW-1:0] idx;
    int            k;
    w   = PW'(v);
    idx = '0;
    for (k = AW - 1; k >= 0; k--) begin
      low_mask = (PW'(1) << (1 << k)) - PW'(1);
      if ((w & low_mask) == '0) begin
        idx[k] = 1'b1;
        w      = w >> (1 << k);
      end
    end
    return idx;
  endfunction

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= gre_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // A count above the node capacity behaves as the capacity.
  assign count_act = (KW'(node_count) > KW'(MAX_NODES)) ? KW'(MAX_NODES) : KW'(node_count);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      count_mask[i] = (KW'(i) < count_act);
    end
  end

  assign req_valid = (KW'(node_a) < count_act) && (KW'(node_b) < count_act);
  assign accept = start && !busy;

  // A query that is out of range or asks for its own start is answered at once.
  assign direct_answer = !req_valid || (node_a == node_b);

  assign pending = reached & ~expanded;
  assign pick = first_set(pending);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gre_pkg::S_IDLE: begin
        if (accept) begin
          if (op == gre_pkg::OP_ADD) begin
            state_next = req_valid ? gre_pkg::S_ADD_RD : gre_pkg::S_IDLE;
          end else begin
            state_next = direct_answer ? gre_pkg::S_IDLE : gre_pkg::S_PICK;
          end
        end
      end
      gre_pkg::S_ADD_RD:   state_next = gre_pkg::S_ADD_WR_A;
      gre_pkg::S_ADD_WR_A: state_next = gre_pkg::S_ADD_WR_B;
      gre_pkg::S_ADD_WR_B: state_next = gre_pkg::S_IDLE;
      gre_pkg::S_PICK: begin
        if (reached[b_q] || (pending == '0)) begin
          state_next = gre_pkg::S_IDLE;
        end else begin
          state_next = gre_pkg::S_EXPAND;
        end
      end
      gre_pkg::S_EXPAND:   state_next = gre_pkg::S_PICK;
      default:             state_next = gre_pkg::S_IDLE;
    endcase
  end

  // Memory control. When both endpoints of an edge are the same node the read of the
  // second row can see the old row, but both writes then carry the same value.
  always_comb begin
    mem_ctl = '0;
    rd_addr = a_q;
    wr_addr = a_q;
    wr_data = rd_data | (MAX_NODES'(1) << b_q);
    unique case (state)
      gre_pkg::S_IDLE: begin
      end
      gre_pkg::S_ADD_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = a_q;
      end
      gre_pkg::S_ADD_WR_A: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = a_q;
        wr_data       = rd_data | (MAX_NODES'(1) << b_q);
        mem_ctl.rd_en = 1'b1;
        rd_addr       = b_q;
      end
      gre_pkg::S_ADD_WR_B: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = b_q;
        wr_data       = rd_data | (MAX_NODES'(1) << a_q);
      end
      gre_pkg::S_PICK: begin
        mem_ctl.rd_en = !reached[b_q] && (pending != '0);
        rd_addr       = pick;
      end
      gre_pkg::S_EXPAND: begin
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != gre_pkg::S_IDLE);

  gre_adj_mem #(
    .MAX_NODES(MAX_NODES)
  ) u_adj_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gre_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_q <= AW'(node_a);
      b_q <= AW'(node_b);
    end
  end

  // Walk state. The reached vector is cleared and seeded with the start node on each query
  // that needs a walk; a node's row, limited to the nodes in use, is merged when expanded.
  always_ff @(posedge clk) begin
    if (rst) begin
      reached  <= '0;
      expanded <= '0;
    end else begin
      if (accept && (op == gre_pkg::OP_QUERY) && !direct_answer) begin
        reached  <= MAX_NODES'(1) << AW'(node_a);
        expanded <= '0;
      end else if (mem_ctl.rd_en && (state == gre_pkg::S_PICK)) begin
        expanded[pick] <= 1'b1;
      end else if (state == gre_pkg::S_EXPAND) begin
        reached <= reached | (rd_data & count_mask);
      end
    end
  end

  // Result register: one cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_q  <= 1'b0;
      reach_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (accept && (op == gre_pkg::OP_QUERY) && direct_answer) begin
        done_q  <= 1'b1;
        reach_q <= req_valid;
      end else if (state == gre_pkg::S_PICK) begin
        if (reached[b_q]) begin
          done_q  <= 1'b1;
          reach_q <= 1'b1;
        end else if (pending == '0) begin
          done_q  <= 1'b1;
          reach_q <= 1'b0;
        end
      end
    end
  end

  assign done      = done_q;
  assign reachable = reach_q;

  // A walk never expands a node it has not reached.
  a_expanded_subset: assert property (
    @(posedge clk) disable iff (rst) ((expanded & ~reached) == '0)
  ) else $error("expanded node outside reached set");

  // The reached set does not lose a node while a row is merged.
  a_reached_grows: assert property (
    @(posedge clk) disable iff (rst)
    (state == gre_pkg::S_EXPAND) |=> ((reached & $past(reached)) == $past(reached))
  ) else $error("reached set lost a node during a walk");

  // A result comes only from an accepted query or the end of a walk.
  a_done_source: assert property (
    @(posedge clk) disable iff (rst)
    done |-> ($past(state) == gre_pkg::S_IDLE || $past(state) == gre_pkg::S_PICK)
  ) else $error("result strobe outside a query");

  // A query that needs a walk holds off further requests.
  a_walk_busy: assert property (
    @(posedge clk) disable iff (rst)
    (accept && (op == gre_pkg::OP_QUERY) && !direct_answer) |=> busy
  ) else $error("walk started without busy");

endmodule
